@@ src/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-128 package
// Payload types, S-box and GF(2^8) helpers shared by the round pipeline.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int Rounds = 10;
  localparam int CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] plaintext_high;
    logic [63:0] plaintext_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] ciphertext_high;
    logic [63:0] ciphertext_low;
  } out_item_t;

  // one stage's payload: state block, current round key and round constant
  typedef struct packed {
    logic [127:0] blk;
    logic [127:0] rkey;
    logic [7:0]   rcon;
  } stage_t;

  function automatic logic [7:0] sbox(input logic [7:0] v);
    logic [7:0] r;
    case (v)
      8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
      8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
      8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
      8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
      8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
      8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
      8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
      8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
      8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
      8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
      8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
      8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
      8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
      8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
      8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
      8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
      8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
      8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
      8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
      8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
      8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
      8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
      8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
      8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
      8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
      8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
      8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
      8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
      8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
      8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
      8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
      8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
      8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
      8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
      8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
      8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
      8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
      8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
      8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
      8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
      8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
      8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
      8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
      8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
      8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
      8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
      8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
      8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
      8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
      8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
      8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
      8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
      8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
      8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
      8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
      8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
      8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
      8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
      8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
      8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
      8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
      8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
      8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
      8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

@@ src/aes_round_cell.sv @@
// ----------------------------------------------------------------------------
// AES round cell
// One round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey, with the
// next round key expanded alongside. Registered output with stall hold.
// ----------------------------------------------------------------------------
module aes_round_cell
  import aes_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   last,
  input  logic   in_valid,
  input  stage_t in_data,
  output logic   in_stall,
  output logic   out_valid,
  output stage_t out_data,
  input  logic   out_stall
);

  logic [7:0]   b   [16];
  logic [7:0]   s   [16];
  logic [7:0]   m   [16];
  logic [31:0]  w   [4];
  logic [31:0]  nw  [4];
  logic [31:0]  t;
  logic [127:0] nkey;
  logic [127:0] nblk;
  logic         load;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      b[k] = in_data.blk[127-8*k -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        s[4*c+r] = sbox(b[4*((c+r)%4)+r]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[4*c]   = xtime(s[4*c]) ^ xtime(s[4*c+1]) ^ s[4*c+1] ^ s[4*c+2] ^ s[4*c+3];
      m[4*c+1] = s[4*c] ^ xtime(s[4*c+1]) ^ xtime(s[4*c+2]) ^ s[4*c+2] ^ s[4*c+3];
      m[4*c+2] = s[4*c] ^ s[4*c+1] ^ xtime(s[4*c+2]) ^ xtime(s[4*c+3]) ^ s[4*c+3];
      m[4*c+3] = xtime(s[4*c]) ^ s[4*c] ^ s[4*c+1] ^ s[4*c+2] ^ xtime(s[4*c+3]);
    end
    for (int c = 0; c < 4; c++) begin
      w[c] = in_data.rkey[127-32*c -: 32];
    end
    t = {sbox(w[3][23:16]) ^ in_data.rcon, sbox(w[3][15:8]), sbox(w[3][7:0]),
         sbox(w[3][31:24])};
    nw[0] = w[0] ^ t;
    nw[1] = w[1] ^ nw[0];
    nw[2] = w[2] ^ nw[1];
    nw[3] = w[3] ^ nw[2];
    nkey = {nw[0], nw[1], nw[2], nw[3]};
    for (int k = 0; k < 16; k++) begin
      nblk[127-8*k -: 8] = (last ? s[k] : m[k]) ^ nkey[127-8*k -: 8];
    end
  end

  assign in_stall = out_valid && out_stall;
  assign load     = !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_data.blk  <= nblk;
      out_data.rkey <= nkey;
      out_data.rcon <= xtime(in_data.rcon);
    end
  end

endmodule

@@ src/aes128_block_encrypt.sv @@
// ----------------------------------------------------------------------------
// AES-128 block encrypt
// Structure: a registered initial key add followed by ten round cells.
// Throughput: one item per cycle through the chain of round cells while out_stall is low.
// Each cell expands its own round key, so the key pipelines with the item.
// Reset clears all valid flags and the key registers to zero.
// ----------------------------------------------------------------------------
module aes128_block_encrypt
  import aes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  in_item_t    in_data,
  output logic        in_stall,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        out_stall
);

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic        v0;
  stage_t      d0;
  logic        s0;
  logic        v    [Rounds+1];
  stage_t      d    [Rounds+1];
  logic        st   [Rounds+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s0 = v0 && st[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (!s0) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!s0 && in_valid) begin
      d0.blk  <= {in_data.plaintext_high, in_data.plaintext_low} ^ {key_high, key_low};
      d0.rkey <= {key_high, key_low};
      d0.rcon <= 8'h01;
    end
  end

  assign in_stall = s0;
  assign v[0]  = v0;
  assign d[0]  = d0;

  for (genvar i = 0; i < Rounds; i++) begin : g_round
    aes_round_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .last      (i == Rounds - 1),
      .in_valid  (v[i]),
      .in_data   (d[i]),
      .in_stall  (st[i]),
      .out_valid (v[i+1]),
      .out_data  (d[i+1]),
      .out_stall (st[i+1])
    );
  end

  assign st[Rounds] = out_stall;
  assign out_valid  = v[Rounds];
  assign out_data.ciphertext_high = d[Rounds].blk[127:64];
  assign out_data.ciphertext_low  = d[Rounds].blk[63:0];

endmodule

@@ test/aes128_block_encrypt_chk.sv @@
// ----------------------------------------------------------------------------
// AES-128 encrypt checker
// Watches the key writes and both item channels, computes each expected
// ciphertext with its own FIPS-197 cipher and compares it with the output.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_chk
  import aes_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  input  in_item_t           in_data,
  input  logic               in_stall,
  input  logic               out_valid,
  input  out_item_t          out_data,
  input  logic               out_stall,
  output int                 errors,
  output int                 pending
);

  logic [63:0] cur_key_high;
  logic [63:0] cur_key_low;
  out_item_t   cipher_q[$];

  logic [7:0] sub_lut[256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf_x2(input logic [7:0] v);
    return (v << 1) ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // bytes indexed 0..15 as in FIPS-197, byte 0 at bits 127:120
  function automatic out_item_t encrypt(input logic [127:0] key, input in_item_t pt);
    logic [31:0]  w[44];
    logic [31:0]  t;
    logic [7:0]   rc;
    logic [7:0]   s[16];
    logic [7:0]   n[16];
    logic [7:0]   a0, a1, a2, a3;
    logic [127:0] blk;
    out_item_t    ct;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sub_lut[t[31:24]], sub_lut[t[23:16]], sub_lut[t[15:8]], sub_lut[t[7:0]]}
            ^ {rc, 24'h0};
        rc = gf_x2(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    blk = {pt.plaintext_high, pt.plaintext_low};
    for (int k = 0; k < 16; k++) s[k] = blk[127-8*k -: 8] ^ w[k/4][31-8*(k%4) -: 8];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int q = 0; q < 4; q++) n[4*c+q] = sub_lut[s[4*((c+q)%4)+q]];
      if (r < 10)
        for (int c = 0; c < 4; c++) begin
          a0 = n[4*c]; a1 = n[4*c+1]; a2 = n[4*c+2]; a3 = n[4*c+3];
          n[4*c]   = gf_x2(a0) ^ gf_x2(a1) ^ a1 ^ a2 ^ a3;
          n[4*c+1] = a0 ^ gf_x2(a1) ^ gf_x2(a2) ^ a2 ^ a3;
          n[4*c+2] = a0 ^ a1 ^ gf_x2(a2) ^ gf_x2(a3) ^ a3;
          n[4*c+3] = gf_x2(a0) ^ a0 ^ a1 ^ a2 ^ gf_x2(a3);
        end
      for (int k = 0; k < 16; k++) s[k] = n[k] ^ w[4*r + k/4][31-8*(k%4) -: 8];
    end
    for (int k = 0; k < 16; k++) blk[127-8*k -: 8] = s[k];
    ct.ciphertext_high = blk[127:64];
    ct.ciphertext_low  = blk[63:0];
    return ct;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %h want %h", what, got, want);
    errors++;
  endtask

  initial errors = 0;
  assign pending = cipher_q.size();

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      cur_key_high <= '0;
      cur_key_low  <= '0;
    end else begin
      if (in_valid && !in_stall)
        cipher_q.push_back(encrypt({cur_key_high, cur_key_low}, in_data));
      if (out_valid && !out_stall) begin
        if (cipher_q.size() == 0) begin
          report("unexpected item", out_data.ciphertext_high, '0);
        end else begin
          want = cipher_q.pop_front();
          if (out_data.ciphertext_high !== want.ciphertext_high)
            report("ciphertext_high", out_data.ciphertext_high, want.ciphertext_high);
          if (out_data.ciphertext_low !== want.ciphertext_low)
            report("ciphertext_low", out_data.ciphertext_low, want.ciphertext_low);
        end
      end
      if (cfg_we) begin
        if (cfg_idx == REG_KEY_HIGH) cur_key_high <= cfg_data;
        else if (cfg_idx == REG_KEY_LOW) cur_key_low <= cfg_data;
      end
    end
  end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// AES-128 encrypt testbench
// Drives key writes and plaintext items in bursts against a stalling
// receiver, over several keys; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import aes_pkg::*;

  localparam int Latency  = 11;
  localparam int IdleMax  = 2000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = REG_KEY_HIGH;
  logic [63:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  in_item_t           in_data = '0;
  logic               in_stall;
  logic               out_valid;
  out_item_t          out_data;
  logic               out_stall = 1'b0;
  int                 errors;
  int                 pending;
  int                 idle_cycles = 0;

  always #6 clk = ~clk;

  aes128_block_encrypt i_dut (.*);
  aes128_block_encrypt_chk i_chk (.*);

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  always @(posedge clk) begin
    int mode;
    mode = int'(($time / 20000) % 3);
    if (mode == 0) out_stall <= 1'b0;
    else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 9) < 6);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleMax) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= REG_KEY_HIGH; cfg_data <= hi;
    @(posedge clk);
    cfg_idx <= REG_KEY_LOW; cfg_data <= lo;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Latency + 2) @(posedge clk);
  endtask

  task automatic send(input logic [63:0] hi, input logic [63:0] lo, input bit gaps);
    if (gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{plaintext_high: hi, plaintext_low: lo};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic finish_burst();
    in_valid <= 1'b0;
  endtask

  task automatic random_run(input int count);
    int burst;
    for (int n = 0; n < count; n++) begin
      burst = $urandom_range(1, 12);
      send(rand64(), rand64(), 1'b0);
      if (n % burst == 0) begin
        finish_burst();
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    finish_burst();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // zero key, never written
    send('0, '0, 1'b0);
    send('1, '1, 1'b0);
    finish_burst();
    drain();
    // FIPS-197 appendix vector and walking bits
    write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    for (int b = 0; b < 64; b += 9) send(64'h1 << b, ~(64'h1 << b), 1'b1);
    finish_burst();
    drain();
    write_key('1, '1);
    send('0, '0, 1'b0);
    send('1, '1, 1'b0);
    send(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
    finish_burst();
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      write_key(rand64(), rand64());
      random_run(210);
      drain();
    end
    write_key('0, '1);
    random_run(15);
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ aes128_block_encrypt.f @@
src/aes_pkg.sv
src/aes_round_cell.sv
src/aes128_block_encrypt.sv
test/aes128_block_encrypt_chk.sv
test/tb.sv
